// ===== hw/rtl/fkin_pkg.sv =====
// Shared constants, types and the skeleton parent table for forward kinematics.
`default_nettype none

package fkin_pkg;

  localparam int JOINT_COUNT = 20;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_WIDTH  = 32;

  // Fixed field widths on the ports
  localparam int JOINT_W = 5;
  localparam int ROW_W   = 2;
  localparam int ELEM_W  = 32;

  localparam int DIM     = 4;
  localparam int ENTRIES = DIM * DIM;
  localparam int STEP_W  = $clog2(ENTRIES);
  localparam int HALF_W  = $clog2(DIM);

  localparam int JIDX_W  = $clog2(JOINT_COUNT);
  localparam int WADDR_W = JIDX_W + STEP_W;
  localparam int WDEPTH  = JOINT_COUNT * ENTRIES;

  localparam int ACC_W  = 64;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int EXT_W  = (PROD_W > ACC_W) ? PROD_W : ACC_W + 1;

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(DIM - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ENTRIES - 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  localparam data_t FIX_ONE  = data_t'(DATA_WIDTH'(1) << FRAC_BITS);
  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam acc_t  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  // One multiply-accumulate step handed from the sequencer to the MAC
  typedef struct packed {
    logic                vld;
    logic [STEP_W-1:0]   step;
    logic [JOINT_W-1:0]  joint;
    logic                row3;
    logic                root;
    data_t               ident;
    data_t               elem;
  } mac_op_t;

  typedef struct packed {
    logic              en;
    logic              keep;
    logic [STEP_W-1:0] addr;
    acc_t              data;
  } acc_wr_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    data_t              data;
  } world_wr_t;

  typedef struct packed {
    logic              root;
    logic [JIDX_W-1:0] idx;
  } parent_t;

  // hip is the root; spine to neck; head and arms under neck; legs under hip
  function automatic parent_t parent_of(input logic [JOINT_W-1:0] joint);
    parent_t            p;
    logic [JOINT_W-1:0] t;
    p.root = 1'b0;
    t      = '0;
    case (joint)
      5'd1:    t = 5'd0;
      5'd2:    t = 5'd1;
      5'd3:    t = 5'd2;
      5'd4:    t = 5'd3;
      5'd5:    t = 5'd4;
      5'd6:    t = 5'd4;
      5'd7:    t = 5'd6;
      5'd8:    t = 5'd7;
      5'd9:    t = 5'd8;
      5'd10:   t = 5'd4;
      5'd11:   t = 5'd10;
      5'd12:   t = 5'd11;
      5'd13:   t = 5'd12;
      5'd14:   t = 5'd0;
      5'd15:   t = 5'd14;
      5'd16:   t = 5'd15;
      5'd17:   t = 5'd0;
      5'd18:   t = 5'd17;
      5'd19:   t = 5'd18;
      default: p.root = 1'b1;
    endcase
    p.idx = JIDX_W'(t);
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fkin_world_ram.sv =====
// World matrix store: one write port, one registered read port.
`default_nettype none

module fkin_world_ram (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [fkin_pkg::WADDR_W-1:0] rd_addr,
  output fkin_pkg::data_t                  rd_data,
  input  fkin_pkg::world_wr_t              wr
);

  fkin_pkg::data_t mem_r [fkin_pkg::WDEPTH];
  fkin_pkg::data_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/fkin_acc_ram.sv =====
// 16-entry accumulator memory with per-entry valid bits (invalid reads as zero).
`default_nettype none

module fkin_acc_ram (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [fkin_pkg::STEP_W-1:0] rd_addr,
  output fkin_pkg::acc_t                  rd_data,
  input  fkin_pkg::acc_wr_t               wr
);

  fkin_pkg::acc_t                      mem_r [fkin_pkg::ENTRIES];
  logic [fkin_pkg::ENTRIES-1:0]        vld_r;
  fkin_pkg::acc_t                      rd_q_r;
  logic                                rd_v_r;

  always_ff @(posedge clk) begin
    if (wr.en && wr.keep) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= wr.keep;
      end
      rd_v_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_v_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/fkin_seq.sv =====
// Input sequencer: holds one row beat and steps through its 16 MAC operations.
`default_nettype none

module fkin_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fkin_pkg::JOINT_W-1:0] in_joint_index,
  input  wire logic [fkin_pkg::ROW_W-1:0]   in_row_index,
  input  wire logic signed [fkin_pkg::ELEM_W-1:0] in_elem0,
  input  wire logic signed [fkin_pkg::ELEM_W-1:0] in_elem1,
  input  wire logic signed [fkin_pkg::ELEM_W-1:0] in_elem2,
  input  wire logic signed [fkin_pkg::ELEM_W-1:0] in_elem3,
  input  wire logic                         res_done,
  input  wire logic                         out_full,
  output logic                              world_rd_en,
  output logic [fkin_pkg::WADDR_W-1:0]      world_rd_addr,
  output logic [fkin_pkg::STEP_W-1:0]       acc_rd_addr,
  output fkin_pkg::mac_op_t                 op
);

  logic                          busy_r;
  logic                          res_r;
  logic [fkin_pkg::STEP_W-1:0]   step_r;
  logic [fkin_pkg::JOINT_W-1:0]  joint_r;
  logic [fkin_pkg::ROW_W-1:0]    row_r;
  logic                          root_r;
  logic [fkin_pkg::JIDX_W-1:0]   par_r;
  fkin_pkg::data_t               elem_r [fkin_pkg::DIM];

  logic                          known;
  logic                          in_row3;
  logic                          last_step;
  logic                          accept;
  logic                          load;
  fkin_pkg::parent_t             par;
  logic [fkin_pkg::HALF_W-1:0]   row_i;
  logic [fkin_pkg::HALF_W-1:0]   col_j;

  assign known     = int'(in_joint_index) < fkin_pkg::JOINT_COUNT;
  assign in_row3   = in_row_index == fkin_pkg::LAST_ROW;
  assign last_step = step_r == fkin_pkg::LAST_STEP;
  // a closing row waits until no result is in flight or unclaimed
  assign in_stall  = (busy_r && !last_step) || (in_row3 && (res_r || out_full));
  assign accept    = in_valid && !in_stall;
  assign load      = accept && known;
  assign par       = fkin_pkg::parent_of(in_joint_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      res_r  <= 1'b0;
      step_r <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
      if (res_done) begin
        res_r <= 1'b0;
      end else if (load && in_row3) begin
        res_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      joint_r   <= in_joint_index;
      row_r     <= in_row_index;
      root_r    <= par.root;
      par_r     <= par.idx;
      elem_r[0] <= fkin_pkg::DATA_WIDTH'($unsigned(in_elem0));
      elem_r[1] <= fkin_pkg::DATA_WIDTH'($unsigned(in_elem1));
      elem_r[2] <= fkin_pkg::DATA_WIDTH'($unsigned(in_elem2));
      elem_r[3] <= fkin_pkg::DATA_WIDTH'($unsigned(in_elem3));
    end
  end

  assign row_i = step_r[fkin_pkg::STEP_W-1:fkin_pkg::HALF_W];
  assign col_j = step_r[fkin_pkg::HALF_W-1:0];

  assign world_rd_en   = busy_r && !root_r;
  assign world_rd_addr = {par_r, row_i, row_r};
  assign acc_rd_addr   = step_r;

  always_comb begin
    op       = '0;
    op.vld   = busy_r;
    op.step  = step_r;
    op.joint = joint_r;
    op.row3  = row_r == fkin_pkg::LAST_ROW;
    op.root  = root_r;
    op.ident = (row_i == row_r) ? fkin_pkg::FIX_ONE : '0;
    op.elem  = elem_r[col_j];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fkin_mac.sv =====
// Shared MAC: multiply, saturating accumulate, finalise to world and result beat.
`default_nettype none

module fkin_mac (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  fkin_pkg::mac_op_t                 op,
  input  fkin_pkg::data_t                   world_rd,
  input  fkin_pkg::acc_t                    acc_rd,
  output fkin_pkg::acc_wr_t                 acc_wr,
  output fkin_pkg::world_wr_t               world_wr,
  output logic                              res_done,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fkin_pkg::JOINT_W-1:0]      out_joint_id,
  output logic signed [fkin_pkg::ELEM_W-1:0] out_pos_x,
  output logic signed [fkin_pkg::ELEM_W-1:0] out_pos_y,
  output logic signed [fkin_pkg::ELEM_W-1:0] out_pos_z,
  output logic                              out_overflow
);

  // translation column entries of the world matrix
  localparam logic [fkin_pkg::STEP_W-1:0] STEP_X = fkin_pkg::STEP_W'(3);
  localparam logic [fkin_pkg::STEP_W-1:0] STEP_Y = fkin_pkg::STEP_W'(7);
  localparam logic [fkin_pkg::STEP_W-1:0] STEP_Z = fkin_pkg::STEP_W'(11);

  fkin_pkg::mac_op_t                   a_r;
  logic                                b_vld_r;
  logic [fkin_pkg::STEP_W-1:0]         b_step_r;
  logic [fkin_pkg::JOINT_W-1:0]        b_joint_r;
  logic                                b_row3_r;
  logic signed [fkin_pkg::PROD_W-1:0]  prod_r;
  fkin_pkg::acc_t                      acc_q_r;
  logic                                sat_r;
  fkin_pkg::data_t                     px_r, py_r, pz_r;
  logic                                out_valid_r;
  logic [fkin_pkg::JOINT_W-1:0]        out_joint_r;
  logic signed [fkin_pkg::ELEM_W-1:0]  out_x_r, out_y_r, out_z_r;
  logic                                out_ovf_r;

  fkin_pkg::data_t                     p;
  logic signed [fkin_pkg::PROD_W-1:0]  prod_nxt;
  logic signed [fkin_pkg::EXT_W-1:0]   prod_ext;
  logic                                mul_ovf;
  fkin_pkg::acc_t                      prod_sat;
  logic [fkin_pkg::ACC_W:0]            sum_w;
  logic                                add_ovf;
  fkin_pkg::acc_t                      sum;
  fkin_pkg::acc_t                      shifted;
  logic                                clamp_ovf;
  fkin_pkg::data_t                     world_val;
  logic                                sat_now;
  logic                                fin;

  // stage A: parent element meets local element
  assign p        = a_r.root ? a_r.ident : world_rd;
  assign prod_nxt = p * a_r.elem;

  // stage B: saturate product, accumulate, finalise on the closing row
  assign prod_ext = fkin_pkg::EXT_W'(prod_r);
  assign mul_ovf  = prod_ext[fkin_pkg::EXT_W-1:fkin_pkg::ACC_W-1] !=
                    {(fkin_pkg::EXT_W-fkin_pkg::ACC_W+1){prod_ext[fkin_pkg::EXT_W-1]}};
  assign prod_sat = mul_ovf ? (prod_ext[fkin_pkg::EXT_W-1] ? fkin_pkg::ACC_MIN
                                                           : fkin_pkg::ACC_MAX)
                            : prod_ext[fkin_pkg::ACC_W-1:0];
  assign sum_w    = {acc_q_r[fkin_pkg::ACC_W-1], acc_q_r} +
                    {prod_sat[fkin_pkg::ACC_W-1], prod_sat};
  assign add_ovf  = sum_w[fkin_pkg::ACC_W] ^ sum_w[fkin_pkg::ACC_W-1];
  assign sum      = add_ovf ? (sum_w[fkin_pkg::ACC_W] ? fkin_pkg::ACC_MIN : fkin_pkg::ACC_MAX)
                            : sum_w[fkin_pkg::ACC_W-1:0];
  assign shifted  = sum >>> fkin_pkg::FRAC_BITS;
  assign clamp_ovf = shifted[fkin_pkg::ACC_W-1:fkin_pkg::DATA_WIDTH-1] !=
                     {(fkin_pkg::ACC_W-fkin_pkg::DATA_WIDTH+1){shifted[fkin_pkg::ACC_W-1]}};
  assign world_val = clamp_ovf ? (shifted[fkin_pkg::ACC_W-1] ? fkin_pkg::DATA_MIN
                                                             : fkin_pkg::DATA_MAX)
                               : shifted[fkin_pkg::DATA_WIDTH-1:0];
  assign sat_now  = mul_ovf || add_ovf || (b_row3_r && clamp_ovf);
  assign fin      = b_vld_r && b_row3_r && (b_step_r == fkin_pkg::LAST_STEP);

  always_comb begin
    acc_wr      = '0;
    acc_wr.en   = b_vld_r;
    acc_wr.keep = !b_row3_r;
    acc_wr.addr = b_step_r;
    acc_wr.data = sum;
    world_wr      = '0;
    world_wr.en   = b_vld_r && b_row3_r;
    world_wr.addr = {b_joint_r[fkin_pkg::JIDX_W-1:0], b_step_r};
    world_wr.data = world_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= '0;
      b_vld_r     <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_r     <= op;
      b_vld_r <= a_r.vld;
      if (b_vld_r) begin
        sat_r <= fin ? 1'b0 : (sat_r || sat_now);
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_step_r  <= a_r.step;
    b_joint_r <= a_r.joint;
    b_row3_r  <= a_r.row3;
    prod_r    <= prod_nxt;
    acc_q_r   <= acc_rd;
    if (b_vld_r && b_row3_r) begin
      if (b_step_r == STEP_X) px_r <= world_val;
      if (b_step_r == STEP_Y) py_r <= world_val;
      if (b_step_r == STEP_Z) pz_r <= world_val;
    end
    if (fin) begin
      out_joint_r <= b_joint_r;
      out_x_r     <= fkin_pkg::ELEM_W'($unsigned(px_r));
      out_y_r     <= fkin_pkg::ELEM_W'($unsigned(py_r));
      out_z_r     <= fkin_pkg::ELEM_W'($unsigned(pz_r));
      out_ovf_r   <= sat_r || sat_now;
    end
  end

  assign res_done     = fin;
  assign out_valid    = out_valid_r;
  assign out_joint_id = out_joint_r;
  assign out_pos_x    = out_x_r;
  assign out_pos_y    = out_y_r;
  assign out_pos_z    = out_z_r;
  assign out_overflow = out_ovf_r;

endmodule

`default_nettype wire

// ===== hw/rtl/skeleton_forward_kinematics.sv =====
// Top level of the 20-joint skeleton forward kinematics block.
`default_nettype none

// Each input beat carries one row k of a joint's local 4x4 transform (signed
// Q16.16). The block adds parent_world[i][k] * local[k][j] into a 16-entry
// 64-bit accumulator; a beat for row 3 closes the joint, writes its world
// matrix to the on-chip store and emits one result beat with the translation
// column, saturated, plus an overflow flag. Send rows and joints in order,
// parents before children; the hip uses the identity as parent, and joint
// numbers from 20 up are taken and dropped. A new row beat is held off until
// the previous one issues its last product, set by the single shared
// multiply-accumulate unit doing one of the 16 products per cycle against the
// world store's one read port. A row 3 beat is held off while the previous
// result is still in flight or not yet taken downstream. No clearing pass
// after reset: the sender must see that the world store is only read for
// parents already written; the block itself does not enforce it.
module skeleton_forward_kinematics (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input rows
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fkin_pkg::JOINT_W-1:0] in_joint_index,
  input  wire logic [fkin_pkg::ROW_W-1:0]   in_row_index,
  input  wire logic signed [fkin_pkg::ELEM_W-1:0] in_elem0,
  input  wire logic signed [fkin_pkg::ELEM_W-1:0] in_elem1,
  input  wire logic signed [fkin_pkg::ELEM_W-1:0] in_elem2,
  input  wire logic signed [fkin_pkg::ELEM_W-1:0] in_elem3,
  // world positions
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fkin_pkg::JOINT_W-1:0]      out_joint_id,
  output logic signed [fkin_pkg::ELEM_W-1:0] out_pos_x,
  output logic signed [fkin_pkg::ELEM_W-1:0] out_pos_y,
  output logic signed [fkin_pkg::ELEM_W-1:0] out_pos_z,
  output logic                              out_overflow
);

  fkin_pkg::mac_op_t                 op;
  logic                              world_rd_en;
  logic [fkin_pkg::WADDR_W-1:0]      world_rd_addr;
  fkin_pkg::data_t                   world_rd;
  fkin_pkg::world_wr_t               world_wr;
  logic [fkin_pkg::STEP_W-1:0]       acc_rd_addr;
  fkin_pkg::acc_t                    acc_rd;
  fkin_pkg::acc_wr_t                 acc_wr;
  logic                              res_done;

  // Sequencer: one step per cycle, i = step[3:2], j = step[1:0]. It issues the
  // parent element read (same address for four steps) and the accumulator
  // read together, so both land in the MAC's first stage.
  fkin_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_joint_index (in_joint_index),
    .in_row_index   (in_row_index),
    .in_elem0       (in_elem0),
    .in_elem1       (in_elem1),
    .in_elem2       (in_elem2),
    .in_elem3       (in_elem3),
    .res_done       (res_done),
    .out_full       (out_valid),
    .world_rd_en    (world_rd_en),
    .world_rd_addr  (world_rd_addr),
    .acc_rd_addr    (acc_rd_addr),
    .op             (op)
  );

  // World store: 16 words per joint. A child's first read of an entry comes only
  // after its parent has written it, so no forwarding is needed.
  fkin_world_ram u_world (
    .clk     (clk),
    .rd_en   (world_rd_en),
    .rd_addr (world_rd_addr),
    .rd_data (world_rd),
    .wr      (world_wr)
  );

  // Accumulator: entry e is read at issue and written back from the MAC's second
  // stage, before the next beat reads e again. The closing row clears the valid
  // bits instead of writing zeros.
  fkin_acc_ram u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (acc_rd_addr),
    .rd_data (acc_rd),
    .wr      (acc_wr)
  );

  // MAC: multiply in the first stage, saturating add and write-back in the
  // second. On the closing row it also floors, clamps and stores the world
  // entry, loading the result register on entry 15.
  fkin_mac u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .world_rd     (world_rd),
    .acc_rd       (acc_rd),
    .acc_wr       (acc_wr),
    .world_wr     (world_wr),
    .res_done     (res_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_joint_id (out_joint_id),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_pos_z    (out_pos_z),
    .out_overflow (out_overflow)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the skeleton forward kinematics block: rows in, joint positions out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fkin_pkg::*;

  // One row beat as the sender offers it
  typedef struct packed {
    logic [JOINT_W-1:0]           joint;
    logic [ROW_W-1:0]             row;
    logic [DIM-1:0][ELEM_W-1:0]   elem;
  } row_beat_t;

  // One world position as the block should report it
  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    data_t              x;
    data_t              y;
    data_t              z;
    logic               ovf;
  } world_pos_t;

  // Per offered beat: whether its position is written out by hand below
  typedef struct packed {
    bit         pinned;
    world_pos_t want;
  } beat_note_t;

  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    logic [ROW_W-1:0]   row;
    logic [ELEM_W-1:0]  e0, e1, e2, e3;
    bit                 pin;
    logic [ELEM_W-1:0]  px, py, pz;
    bit                 povf;
  } plan_row_t;

  localparam int PLAN_ROWS   = 23;
  localparam int RANDOM_ROWS = 950;
  localparam int LONG_HOLD   = 600;
  localparam int HOLD_AFTER  = 60;

  // Directed rows. Positions are typed in where they follow directly from
  // the rows (hip only, identity parent); everything else goes to the model.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // hip with extreme diagonal and translation
    '{0, 0, 32'h7fffffff, 32'h0, 32'h0, 32'h7fffffff, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 1, 32'h0, 32'h80000000, 32'h0, 32'h80000000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 2, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 3, 32'h0, 32'h0, 32'h0, 32'h00010000,
      1, 32'h7fffffff, 32'h80000000, 32'h0, 0},
    // spine under the extreme hip: accumulator and output both saturate
    '{1, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      0, 32'h0, 32'h0, 32'h0, 0},
    '{1, 1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      0, 32'h0, 32'h0, 32'h0, 0},
    '{1, 2, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      0, 32'h0, 32'h0, 32'h0, 0},
    '{1, 3, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      0, 32'h0, 32'h0, 32'h0, 0},
    // joints past the skeleton: dropped, no result
    '{31, 3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
      0, 32'h0, 32'h0, 32'h0, 0},
    '{20, 0, 32'h12345678, 32'hedcba987, 32'h5a5a5a5a, 32'ha5a5a5a5,
      0, 32'h0, 32'h0, 32'h0, 0},
    // hip with row 1 left out
    '{0, 0, 32'h00010000, 32'h0, 32'h0, 32'h00030000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 2, 32'h0, 32'h0, 32'h00010000, 32'hfffb0000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 3, 32'h0, 32'h0, 32'h0, 32'h00010000,
      1, 32'h00030000, 32'h0, 32'hfffb0000, 0},
    // hip with row 0 sent twice
    '{0, 0, 32'h00010000, 32'h0, 32'h0, 32'h00020000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 0, 32'h00010000, 32'h0, 32'h0, 32'h00020000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 1, 32'h0, 32'h00010000, 32'h0, 32'h00050000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 2, 32'h0, 32'h0, 32'h00010000, 32'h00060000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{0, 3, 32'h0, 32'h0, 32'h0, 32'h00010000,
      1, 32'h00040000, 32'h00050000, 32'h00060000, 0},
    // left leg row wedged into the second spine joint
    '{2, 0, 32'h00010000, 32'h0, 32'h0, 32'h00010000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{14, 1, 32'h0, 32'h00010000, 32'h0, 32'hffff0000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{2, 2, 32'h0, 32'h0, 32'h00010000, 32'h00020000, 0, 32'h0, 32'h0, 32'h0, 0},
    '{2, 3, 32'h0, 32'h0, 32'h0, 32'h00010000, 0, 32'h0, 32'h0, 32'h0, 0},
    // row 3 alone on the hip: translation column stays zero
    '{0, 3, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      1, 32'h0, 32'h0, 32'h0, 0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [JOINT_W-1:0]        in_joint_index;
  logic [ROW_W-1:0]          in_row_index;
  logic signed [ELEM_W-1:0]  in_elem0, in_elem1, in_elem2, in_elem3;
  logic                      out_valid;
  logic                      out_stall;
  logic [JOINT_W-1:0]        out_joint_id;
  logic signed [ELEM_W-1:0]  out_pos_x, out_pos_y, out_pos_z;
  logic                      out_overflow;

  // Model state: world matrices, the open accumulator and its sticky flag
  data_t      limb_world [JOINT_COUNT][ENTRIES];
  acc_t       chain_acc [ENTRIES];
  bit         chain_sat;

  world_pos_t pos_expect_q [$];
  beat_note_t beat_note_q [$];
  bit         closed_joint [JOINT_COUNT];   // sender side: joints already closed
  bit         calm;                         // no idling on either side
  int         rows_sent;
  int         rows_taken;
  int         ignored_beats;
  int         results_checked;
  int         overflow_seen;
  int         fail_count;

  always #2 clk = ~clk;

  skeleton_forward_kinematics dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_joint_index (in_joint_index),
    .in_row_index   (in_row_index),
    .in_elem0       (in_elem0),
    .in_elem1       (in_elem1),
    .in_elem2       (in_elem2),
    .in_elem3       (in_elem3),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_joint_id   (out_joint_id),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_overflow   (out_overflow)
  );

  // Skeleton hierarchy; -1 marks a joint hung off the identity (the hip)
  function automatic int parent_joint(input int j);
    case (j)
      1, 14, 17: return 0;
      2:         return 1;
      3:         return 2;
      4:         return 3;
      5, 6, 10:  return 4;
      7:         return 6;
      8:         return 7;
      9:         return 8;
      11:        return 10;
      12:        return 11;
      13:        return 12;
      15:        return 14;
      16:        return 15;
      18:        return 17;
      19:        return 18;
      default:   return -1;
    endcase
  endfunction

  // A child may only go once its parent's world matrix is in the store
  function automatic bit can_send(input int j);
    int up;
    up = parent_joint(j);
    return (j >= JOINT_COUNT) || (up < 0) || closed_joint[up];
  endfunction

  // Adds parent_world[.][k] * local[k][.] into the accumulator; row 3 closes
  // the joint, stores its world matrix and queues the translation column.
  task automatic accumulate_row(input row_beat_t b);
    int                    jn, k, up, i, j, n;
    acc_t                  pw, lw, prod, shifted;
    logic signed [ACC_W:0] wide;
    world_pos_t            pos;
    jn = b.joint;
    k  = b.row;
    if (jn >= JOINT_COUNT) return;
    up = parent_joint(jn);
    for (i = 0; i < DIM; i++) begin
      if (up < 0) pw = (i == k) ? acc_t'(FIX_ONE) : acc_t'(0);
      else pw = limb_world[up][i*DIM + k];
      for (j = 0; j < DIM; j++) begin
        n    = i*DIM + j;
        lw   = $signed(b.elem[j]);
        prod = pw * lw;   // 32x32 signed always fits in 64 bits
        wide = {chain_acc[n][ACC_W-1], chain_acc[n]} + {prod[ACC_W-1], prod};
        if (wide[ACC_W] != wide[ACC_W-1]) begin
          chain_acc[n] = wide[ACC_W] ? ACC_MIN : ACC_MAX;
          chain_sat    = 1'b1;
        end else begin
          chain_acc[n] = wide[ACC_W-1:0];
        end
      end
    end
    if (b.row != LAST_ROW) return;
    for (n = 0; n < ENTRIES; n++) begin
      shifted = chain_acc[n] >>> FRAC_BITS;   // floor
      if (shifted > DATA_MAX) begin
        limb_world[jn][n] = DATA_MAX;
        chain_sat = 1'b1;
      end else if (shifted < DATA_MIN) begin
        limb_world[jn][n] = DATA_MIN;
        chain_sat = 1'b1;
      end else begin
        limb_world[jn][n] = shifted[DATA_WIDTH-1:0];
      end
    end
    pos.joint = b.joint;
    pos.x     = limb_world[jn][3];
    pos.y     = limb_world[jn][7];
    pos.z     = limb_world[jn][11];
    pos.ovf   = chain_sat;
    pos_expect_q.push_back(pos);
    for (n = 0; n < ENTRIES; n++) chain_acc[n] = '0;
    chain_sat = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [ELEM_W-1:0] exp,
                             input logic [ELEM_W-1:0] act);
    if (act !== exp) begin
      $error("%s: expected %h, got %h", name, exp, act);
      fail_count++;
    end
  endtask

  // Mostly small rotation-like values, some full-range, some corners
  function automatic logic [ELEM_W-1:0] pick_elem();
    int c;
    c = $urandom_range(99);
    if (c < 55) return $urandom_range(262143) - 32'd131072;
    if (c < 80) return $urandom();
    case ($urandom_range(6))
      0:       return 32'h0;
      1:       return 32'h00010000;
      2:       return 32'hffff0000;
      3:       return 32'h7fffffff;
      4:       return 32'h80000000;
      5:       return 32'h1;
      default: return 32'hffffffff;
    endcase
  endfunction

  function automatic row_beat_t fresh_row(input int j, input int r);
    row_beat_t b;
    int        e;
    b.joint = JOINT_W'(j);
    b.row   = ROW_W'(r);
    for (e = 0; e < DIM; e++) b.elem[e] = pick_elem();
    return b;
  endfunction

  // Stray beat: any joint number, any row; an unreachable child falls back
  // to the hip so that no unwritten parent is ever read
  function automatic row_beat_t stray_row();
    int j;
    j = $urandom_range(31);
    if (!can_send(j)) j = 0;
    return fresh_row(j, $urandom_range(DIM - 1));
  endfunction

  // Offers one beat and holds it until taken
  task automatic send_row(input row_beat_t b, input bit pinned, input world_pos_t want);
    beat_note_t note;
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    note.pinned = pinned;
    note.want   = want;
    beat_note_q.push_back(note);
    in_valid       <= 1'b1;
    in_joint_index <= b.joint;
    in_row_index   <= b.row;
    in_elem0       <= b.elem[0];
    in_elem1       <= b.elem[1];
    in_elem2       <= b.elem[2];
    in_elem3       <= b.elem[3];
    if (b.joint < JOINT_COUNT) begin
      rows_sent++;
      if (b.row == LAST_ROW) closed_joint[b.joint] = 1'b1;
    end
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Sender falls silent until every queued position has come back.
  // It first lets the last accepted beat reach the model.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pos_expect_q.size() != 0) @(posedge clk);
  endtask

  // Whole skeleton in order; a few rows dropped, doubled or preceded by a stray
  task automatic send_frame();
    row_beat_t b;
    int        j, r, dice;
    for (j = 0; j < JOINT_COUNT; j++) begin
      if (!can_send(j)) continue;
      for (r = 0; r < DIM; r++) begin
        dice = $urandom_range(99);
        if (dice < 3) continue;
        if (dice < 6) send_row(stray_row(), 1'b0, '0);
        b = fresh_row(j, r);
        send_row(b, 1'b0, '0);
        if (dice >= 6 && dice < 9) send_row(b, 1'b0, '0);
      end
    end
  endtask

  // Model state follows the block: updated on every taken beat, results
  // matched in order against the oldest expected position.
  always @(posedge clk) begin : scoreboard
    row_beat_t  b;
    beat_note_t note;
    int         before_n;
    if (rst_n === 1'b1) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        b.joint   = in_joint_index;
        b.row     = in_row_index;
        b.elem[0] = in_elem0;
        b.elem[1] = in_elem1;
        b.elem[2] = in_elem2;
        b.elem[3] = in_elem3;
        before_n  = pos_expect_q.size();
        accumulate_row(b);
        note = beat_note_q.pop_front();
        if (note.pinned && pos_expect_q.size() > before_n) pos_expect_q[$] = note.want;
        if (b.joint >= JOINT_COUNT) ignored_beats++;
        else rows_taken++;
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pos_expect_q.size() == 0) begin
          $error("result beat for joint %0d with nothing expected", out_joint_id);
          fail_count++;
        end else begin
          world_pos_t want;
          want = pos_expect_q.pop_front();
          results_checked++;
          if (out_overflow === 1'b1) overflow_seen++;
          check_field("joint_id", ELEM_W'(want.joint), ELEM_W'(out_joint_id));
          check_field("pos_x", want.x, out_pos_x);
          check_field("pos_y", want.y, out_pos_y);
          check_field("pos_z", want.z, out_pos_z);
          check_field("overflow", ELEM_W'(want.ovf), ELEM_W'(out_overflow));
        end
      end
    end
  end

  // Downstream: random stall, except one long hold-off once a few dozen
  // results are in, so the block backs up into its input
  initial begin : receiver
    int hold_left;
    int taken;
    bit long_done;
    hold_left = 0;
    taken     = 0;
    long_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) taken++;
      if (!long_done && taken >= HOLD_AFTER) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!calm && $urandom_range(99) < 21);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    int         n, frame, burst;
    row_beat_t  b;
    world_pos_t want;
    calm            = 1'b0;
    rows_sent       = 0;
    rows_taken      = 0;
    ignored_beats   = 0;
    results_checked = 0;
    overflow_seen   = 0;
    fail_count      = 0;
    chain_sat       = 1'b0;
    for (n = 0; n < ENTRIES; n++) chain_acc[n] = '0;
    for (n = 0; n < JOINT_COUNT; n++) closed_joint[n] = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_joint_index <= '0;
    in_row_index   <= '0;
    in_elem0       <= '0;
    in_elem1       <= '0;
    in_elem2       <= '0;
    in_elem3       <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (n = 0; n < PLAN_ROWS; n++) begin
      b.joint   = PLAN[n].joint;
      b.row     = PLAN[n].row;
      b.elem[0] = PLAN[n].e0;
      b.elem[1] = PLAN[n].e1;
      b.elem[2] = PLAN[n].e2;
      b.elem[3] = PLAN[n].e3;
      want      = '{PLAN[n].joint, PLAN[n].px, PLAN[n].py, PLAN[n].pz, PLAN[n].povf};
      send_row(b, PLAN[n].pin, want);
    end
    drain_results();

    // random frames; frames 6 and 7 run flat out, frame 9 waits for the
    // pipe to empty before it starts
    frame = 0;
    while (rows_sent < PLAN_ROWS + RANDOM_ROWS) begin
      calm = (frame == 6 || frame == 7);
      if (frame == 9) drain_results();
      if ($urandom_range(4) == 0) begin
        burst = $urandom_range(15, 5);
        repeat (burst) send_row(stray_row(), 1'b0, '0);
      end
      send_frame();
      frame++;
    end
    calm = 1'b0;
    drain_results();
    repeat (40) @(posedge clk);

    $display("rows taken %0d, ignored beats %0d, positions checked %0d, overflow on %0d",
             rows_taken, ignored_beats, results_checked, overflow_seen);
    $display("covered hip extremes, saturation, dropped/doubled/stray rows, a long hold-off");
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
